### sv/fsl_pkg.sv
// Shared types, constants and codes for the sequential fade light sequencer.
package fsl_pkg;

    localparam int unsigned MAX_LIGHTS   = 16;
    localparam int unsigned DUTY_W       = 12;
    localparam int unsigned COUNT_W      = 5;
    localparam int unsigned CHAN_W       = 4;
    localparam int unsigned IDX_W        = 6;
    localparam int unsigned HOLD_W       = 20;
    localparam int unsigned CFG_IDX_W    = 2;

    localparam logic [HOLD_W-1:0]  ELAPSED_MAX = {HOLD_W{1'b1}};
    localparam logic [DUTY_W-1:0]  TARGET_RESET = {DUTY_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_LIGHTS);
    localparam logic [COUNT_W-1:0] COUNT_MIN = COUNT_W'(1);

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_ON     = 3'd1,
        OP_OFF    = 3'd2,
        OP_BLINK  = 3'd3,
        OP_TOGGLE = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_ON    = 2'd1,
        MODE_OFF   = 2'd2,
        MODE_BLINK = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 2'd0,
        CFG_COUNT  = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  target;
        logic [COUNT_W-1:0] count;
    } cfg_t;

    typedef struct packed {
        logic [2:0]        opcode;
        logic              go_reverse;
        logic [DUTY_W-1:0] ramp_step;
        logic [HOLD_W-1:0] hold_ticks;
    } item_t;

    typedef struct packed {
        logic              write_valid;
        logic [CHAN_W-1:0] pwm_channel;
        logic [DUTY_W-1:0] pwm_duty;
        logic              lights_on;
        logic              busy_res;
    } result_t;

    typedef struct packed {
        mode_t                    mode;
        logic                     lit;
        logic                     pending;
        logic                     dir_reverse;
        logic [DUTY_W-1:0]        step_size;
        logic [HOLD_W-1:0]        hold_limit;
        logic signed [IDX_W-1:0]  light_index;
        logic [DUTY_W-1:0]        level;
        logic [HOLD_W-1:0]        elapsed;
    } state_t;

endpackage

### sv/sequential_fade_light_sequencer.sv
// Top level of the sequential fade light sequencer: ports, registers and handshakes.
//
//  channel   direction  handshake              contents
//  s_*       in         s_valid / s_ready      opcode, go_reverse, ramp_step, hold_ticks
//  m_*       out        m_valid / m_ready      write_valid, pwm_channel, pwm_duty,
//                                              lights_on, busy_res
//  cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word in, one word out. A word is held in the input register and
// is worked in a single pass into the result register, and a new word is
// taken every cycle while the result side keeps draining.
// The ramp adder, clamp and index step between input and result registers set
// the cycle. A stalled result holds the pipe; s_ready drops only when both
// registers are full and m_ready is low. Reset clears all animation state and
// loads target 4095 and light count 16; the block takes words the cycle after.
module sequential_fade_light_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_opcode,
    input  logic                                s_go_reverse,
    input  logic [fsl_pkg::DUTY_W-1:0]          s_ramp_step,
    input  logic [fsl_pkg::HOLD_W-1:0]          s_hold_ticks,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_write_valid,
    output logic [fsl_pkg::CHAN_W-1:0]          m_pwm_channel,
    output logic [fsl_pkg::DUTY_W-1:0]          m_pwm_duty,
    output logic                                m_lights_on,
    output logic                                m_busy_res,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fsl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fsl_pkg::DUTY_W-1:0]          cfg_data
);

    fsl_pkg::cfg_t    cfg_reg;
    fsl_pkg::item_t   in_reg;
    logic             in_valid_reg;
    fsl_pkg::result_t out_reg;
    fsl_pkg::result_t res;
    logic             out_valid_reg;
    logic             step_en;

    // Configuration writes land at once; indexes beyond the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target <= fsl_pkg::TARGET_RESET;
            cfg_reg.count  <= fsl_pkg::COUNT_MAX;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                fsl_pkg::CFG_TARGET: cfg_reg.target <= cfg_data;
                fsl_pkg::CFG_COUNT:  cfg_reg.count  <= cfg_data[fsl_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Advance the held word whenever the result register is free or draining
    assign step_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Capture payload on accept only; hold it otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.opcode     <= s_opcode;
            in_reg.go_reverse <= s_go_reverse;
            in_reg.ramp_step  <= s_ramp_step;
            in_reg.hold_ticks <= s_hold_ticks;
        end
    end

    fsl_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .cfg     (cfg_reg),
        .item    (in_reg),
        .res     (res)
    );

    // Result register: load on a step, drop the flag once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_write_valid = out_reg.write_valid;
    assign m_pwm_channel = out_reg.pwm_channel;
    assign m_pwm_duty    = out_reg.pwm_duty;
    assign m_lights_on   = out_reg.lights_on;
    assign m_busy_res    = out_reg.busy_res;

endmodule

### sv/fsl_engine.sv
// Animation state registers and the single-pass next-state and result logic.
module fsl_engine (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  fsl_pkg::cfg_t    cfg,
    input  fsl_pkg::item_t   item,
    output fsl_pkg::result_t res
);

    fsl_pkg::state_t st_reg;
    fsl_pkg::state_t st_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.mode        <= fsl_pkg::MODE_IDLE;
            st_reg.lit         <= 1'b0;
            st_reg.pending     <= 1'b0;
            st_reg.dir_reverse <= 1'b0;
            st_reg.step_size   <= '0;
            st_reg.hold_limit  <= '0;
            st_reg.light_index <= '0;
            st_reg.level       <= '0;
            st_reg.elapsed     <= '0;
        end else if (step_en) begin
            st_reg <= st_next;
        end
    end

    // Effective light count, clamped to 1..MAX_LIGHTS
    logic [fsl_pkg::COUNT_W-1:0] count_eff;
    logic [fsl_pkg::IDX_W-1:0]   count6;

    always_comb begin
        if (cfg.count < fsl_pkg::COUNT_MIN) begin
            count_eff = fsl_pkg::COUNT_MIN;
        end else if (cfg.count > fsl_pkg::COUNT_MAX) begin
            count_eff = fsl_pkg::COUNT_MAX;
        end else begin
            count_eff = cfg.count;
        end
        count6 = fsl_pkg::IDX_W'(count_eff);
    end

    // Index step from the current light, shared by both ramp directions
    logic [fsl_pkg::IDX_W-1:0] adv_idx;
    logic                      adv_in;
    logic                      adv_end;

    always_comb begin
        adv_idx = st_reg.dir_reverse ? st_reg.light_index - 1'b1
                                     : st_reg.light_index + 1'b1;
        adv_in  = !adv_idx[fsl_pkg::IDX_W-1] && (adv_idx < count6);
        adv_end = st_reg.dir_reverse ? adv_idx[fsl_pkg::IDX_W-1]
                                     : (!adv_idx[fsl_pkg::IDX_W-1] && (adv_idx >= count6));
    end

    // Ramp up: climb to target, else move to the next light at zero
    logic [fsl_pkg::DUTY_W:0]    up_sum;
    logic [fsl_pkg::DUTY_W-1:0]  up_level;
    logic [fsl_pkg::IDX_W-1:0]   up_idx;
    logic                        up_emit;
    logic                        up_done;

    always_comb begin
        up_sum = {1'b0, st_reg.level} + {1'b0, st_reg.step_size};
        if (st_reg.level < cfg.target) begin
            up_level = (up_sum > {1'b0, cfg.target}) ? cfg.target
                                                     : up_sum[fsl_pkg::DUTY_W-1:0];
            up_idx   = st_reg.light_index;
            up_emit  = 1'b1;
            up_done  = 1'b0;
        end else begin
            up_level = adv_in ? '0 : st_reg.level;
            up_idx   = adv_idx;
            up_emit  = adv_in;
            up_done  = adv_end;
        end
    end

    // Ramp down: fall to zero, else move to the next light at target
    logic [fsl_pkg::DUTY_W-1:0]  dn_level;
    logic [fsl_pkg::IDX_W-1:0]   dn_idx;
    logic                        dn_emit;
    logic                        dn_done;

    always_comb begin
        if (st_reg.level != '0) begin
            dn_level = (st_reg.step_size >= st_reg.level) ? '0
                                                          : st_reg.level - st_reg.step_size;
            dn_idx   = st_reg.light_index;
            dn_emit  = 1'b1;
            dn_done  = 1'b0;
        end else begin
            dn_level = adv_in ? cfg.target : st_reg.level;
            dn_idx   = adv_idx;
            dn_emit  = adv_in;
            dn_done  = adv_end;
        end
    end

    logic [fsl_pkg::HOLD_W-1:0] el_inc;
    logic [fsl_pkg::IDX_W-1:0]  start_old;
    logic [fsl_pkg::IDX_W-1:0]  start_new;

    always_comb begin
        el_inc    = (st_reg.elapsed < fsl_pkg::ELAPSED_MAX) ? st_reg.elapsed + 1'b1
                                                            : st_reg.elapsed;
        start_old = st_reg.dir_reverse ? count6 - 1'b1 : '0;
        start_new = item.go_reverse ? count6 - 1'b1 : '0;
    end

    always_comb begin
        st_next         = st_reg;
        res.write_valid = 1'b0;
        res.pwm_channel = '0;
        res.pwm_duty    = '0;

        case (item.opcode)
            fsl_pkg::OP_TICK: begin
                st_next.elapsed = el_inc;
                unique case (st_reg.mode)
                    fsl_pkg::MODE_ON: begin
                        st_next.level       = up_level;
                        st_next.light_index = up_idx;
                        res.write_valid     = up_emit;
                        if (up_done) begin
                            st_next.lit     = 1'b1;
                            st_next.pending = 1'b0;
                            st_next.mode    = fsl_pkg::MODE_IDLE;
                        end
                    end
                    fsl_pkg::MODE_OFF: begin
                        st_next.level       = dn_level;
                        st_next.light_index = dn_idx;
                        res.write_valid     = dn_emit;
                        if (dn_done) begin
                            st_next.lit     = 1'b0;
                            st_next.pending = 1'b0;
                            st_next.mode    = fsl_pkg::MODE_IDLE;
                        end
                    end
                    fsl_pkg::MODE_BLINK: begin
                        if (!st_reg.lit) begin
                            st_next.level       = up_level;
                            st_next.light_index = up_idx;
                            res.write_valid     = up_emit;
                            st_next.lit         = up_done;
                            st_next.elapsed     = '0;
                        end else if (el_inc >= st_reg.hold_limit) begin
                            // Hold over: restart straight into a fade-off
                            st_next.pending     = 1'b1;
                            st_next.mode        = fsl_pkg::MODE_OFF;
                            st_next.elapsed     = '0;
                            st_next.level       = cfg.target;
                            st_next.light_index = start_old;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            fsl_pkg::OP_ON, fsl_pkg::OP_OFF, fsl_pkg::OP_BLINK, fsl_pkg::OP_TOGGLE: begin
                st_next.dir_reverse = item.go_reverse;
                st_next.step_size   = item.ramp_step;
                st_next.hold_limit  = item.hold_ticks;
                if (!st_reg.pending) begin
                    if (item.opcode == fsl_pkg::OP_BLINK) begin
                        st_next.pending     = 1'b1;
                        st_next.mode        = fsl_pkg::MODE_BLINK;
                        st_next.level       = '0;
                        st_next.light_index = start_new;
                    end else if ((item.opcode == fsl_pkg::OP_TOGGLE)
                              || (item.opcode == fsl_pkg::OP_ON && !st_reg.lit)
                              || (item.opcode == fsl_pkg::OP_OFF && st_reg.lit)) begin
                        st_next.pending     = 1'b1;
                        st_next.mode        = st_reg.lit ? fsl_pkg::MODE_OFF
                                                         : fsl_pkg::MODE_ON;
                        st_next.elapsed     = '0;
                        st_next.level       = st_reg.lit ? cfg.target : '0;
                        st_next.light_index = start_new;
                    end
                end
            end
            default: begin
            end
        endcase

        if (res.write_valid) begin
            res.pwm_channel = st_next.light_index[fsl_pkg::CHAN_W-1:0];
            res.pwm_duty    = st_next.level;
        end
        res.lights_on = st_next.lit;
        res.busy_res  = st_next.pending;
    end

endmodule

### sv/fsl_checker.sv
// Port-level checks for the sequencer, bound onto the top level.
module fsl_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_write_valid,
    input logic [fsl_pkg::CHAN_W-1:0]    m_pwm_channel,
    input logic [fsl_pkg::DUTY_W-1:0]    m_pwm_duty,
    input logic                          m_lights_on,
    input logic                          m_busy_res
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pwm_duty)
            && $stable(m_pwm_channel) && $stable(m_write_valid)
            && $stable(m_lights_on) && $stable(m_busy_res))
        else $error("result word changed while stalled");

    // A word without a light write carries zero channel and duty
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_valid |-> m_pwm_channel == '0 && m_pwm_duty == '0)
        else $error("channel or duty set without a write");

    // Every light write belongs to a running animation
    a_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_valid |-> m_busy_res)
        else $error("light write reported while not busy");

    // An empty result side never blocks the input
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // Reset empties the pipe
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipe not empty after reset");

endmodule

bind sequential_fade_light_sequencer fsl_checker u_fsl_checker (.*);

### verif/testbench.sv
// Self-checking testbench for the sequential fade light sequencer.
module testbench;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 7;
    localparam int CYCLE_LIMIT     = 400_000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 4;

    // opcodes outside the defined set: the block must ignore them
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    // animation state as the block should hold it
    typedef struct packed {
        fsl_pkg::mode_t                   mode;
        logic                             lit;
        logic                             pending;
        logic                             rev;
        logic [fsl_pkg::DUTY_W-1:0]       step;
        logic [fsl_pkg::HOLD_W-1:0]       hold;
        logic signed [fsl_pkg::IDX_W-1:0] idx;
        logic [fsl_pkg::DUTY_W-1:0]       level;
        logic [fsl_pkg::HOLD_W-1:0]       elapsed;
    } lamp_state_t;

    typedef struct packed {
        logic [fsl_pkg::DUTY_W-1:0]  target;
        logic [fsl_pkg::COUNT_W-1:0] count;
    } lamp_cfg_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_write_valid;
    logic [fsl_pkg::CHAN_W-1:0]    m_pwm_channel;
    logic [fsl_pkg::DUTY_W-1:0]    m_pwm_duty;
    logic                          m_lights_on;
    logic                          m_busy_res;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [fsl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [fsl_pkg::DUTY_W-1:0]    cfg_data = '0;

    // word currently offered on the input channel; the ports follow it
    fsl_pkg::item_t cur_word = '0;

    fsl_pkg::item_t   cmd_queue[$];
    fsl_pkg::result_t pwm_expect_q[$];

    // plan_* runs ahead while words are queued, track_* runs as words are taken
    lamp_state_t plan_st  = '0;
    lamp_state_t track_st = '0;
    lamp_cfg_t   plan_cfg = '{target: fsl_pkg::TARGET_RESET, count: fsl_pkg::COUNT_MAX};
    lamp_cfg_t   track_cfg = '{target: fsl_pkg::TARGET_RESET, count: fsl_pkg::COUNT_MAX};

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    logic hold_request  = 1'b0;
    logic hold_off      = 1'b0;
    logic word_taken    = 1'b0;
    int  mismatches     = 0;
    int  results_seen   = 0;
    int  cycle_count    = 0;

    logic [2:0]                 s_opcode_w;
    logic                       s_go_reverse_w;
    logic [fsl_pkg::DUTY_W-1:0] s_ramp_step_w;
    logic [fsl_pkg::HOLD_W-1:0] s_hold_ticks_w;

    assign {s_opcode_w, s_go_reverse_w, s_ramp_step_w, s_hold_ticks_w} = cur_word;

    sequential_fade_light_sequencer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode_w),
        .s_go_reverse  (s_go_reverse_w),
        .s_ramp_step   (s_ramp_step_w),
        .s_hold_ticks  (s_hold_ticks_w),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_write_valid (m_write_valid),
        .m_pwm_channel (m_pwm_channel),
        .m_pwm_duty    (m_pwm_duty),
        .m_lights_on   (m_lights_on),
        .m_busy_res    (m_busy_res),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Work out the result of one word and the state it leaves behind.
    // A tick runs the active ramp: climb to the target or fall to zero, and
    // once the current light has arrived, step the index and write the next
    // light's starting duty. Commands always load direction, step and hold.
    function automatic void fade_step(input lamp_state_t cur, input lamp_cfg_t cfg,
                                      input fsl_pkg::item_t w,
                                      output lamp_state_t nxt,
                                      output fsl_pkg::result_t res);
        int                         lights;
        int                         pos;
        logic [fsl_pkg::DUTY_W:0]   raised;
        logic                       climbing;
        logic                       falling;
        logic                       finished;
        logic                       launch;
        fsl_pkg::mode_t             launch_mode;
        nxt         = cur;
        res         = '0;
        finished    = 1'b0;
        launch      = 1'b0;
        launch_mode = fsl_pkg::MODE_IDLE;
        // a count outside 1..MAX_LIGHTS is clamped
        if (cfg.count == 0) begin
            lights = 1;
        end else if (cfg.count > fsl_pkg::MAX_LIGHTS) begin
            lights = fsl_pkg::MAX_LIGHTS;
        end else begin
            lights = int'(cfg.count);
        end

        if (w.opcode == fsl_pkg::OP_TICK) begin
            if (nxt.elapsed != fsl_pkg::ELAPSED_MAX) begin
                nxt.elapsed = nxt.elapsed + 1'b1;
            end
            climbing = (nxt.mode == fsl_pkg::MODE_ON)
                    || (nxt.mode == fsl_pkg::MODE_BLINK && !nxt.lit);
            falling  = (nxt.mode == fsl_pkg::MODE_OFF);
            if (climbing && nxt.level < cfg.target) begin
                raised = nxt.level + nxt.step;
                nxt.level = (raised > cfg.target) ? cfg.target
                                                  : raised[fsl_pkg::DUTY_W-1:0];
                res.write_valid = 1'b1;
            end else if (falling && nxt.level != 0) begin
                nxt.level = (nxt.step >= nxt.level) ? fsl_pkg::DUTY_W'(0)
                                                    : nxt.level - nxt.step;
                res.write_valid = 1'b1;
            end else if (climbing || falling) begin
                // index wraps in six bits; beyond the count nothing is written
                nxt.idx = nxt.rev ? nxt.idx - 1'b1 : nxt.idx + 1'b1;
                pos = int'($signed(nxt.idx));
                if (pos >= 0 && pos < lights) begin
                    nxt.level = climbing ? fsl_pkg::DUTY_W'(0) : cfg.target;
                    res.write_valid = 1'b1;
                end
                finished = nxt.rev ? (pos < 0) : (pos >= lights);
            end
            if (res.write_valid) begin
                res.pwm_channel = nxt.idx[fsl_pkg::CHAN_W-1:0];
                res.pwm_duty    = nxt.level;
            end
            case (nxt.mode)
                fsl_pkg::MODE_ON: begin
                    if (finished) begin
                        nxt.lit     = 1'b1;
                        nxt.pending = 1'b0;
                        nxt.mode    = fsl_pkg::MODE_IDLE;
                    end
                end
                fsl_pkg::MODE_OFF: begin
                    if (finished) begin
                        nxt.lit     = 1'b0;
                        nxt.pending = 1'b0;
                        nxt.mode    = fsl_pkg::MODE_IDLE;
                    end
                end
                fsl_pkg::MODE_BLINK: begin
                    if (climbing) begin
                        nxt.lit     = finished;
                        nxt.elapsed = '0;
                    end else if (nxt.elapsed >= nxt.hold) begin
                        // hold over: fade off straight away
                        nxt.pending = 1'b0;
                        launch      = 1'b1;
                        launch_mode = fsl_pkg::MODE_OFF;
                    end
                end
                default: ;
            endcase
        end else if (w.opcode >= fsl_pkg::OP_ON && w.opcode <= fsl_pkg::OP_TOGGLE) begin
            nxt.rev  = w.go_reverse;
            nxt.step = w.ramp_step;
            nxt.hold = w.hold_ticks;
            if (!nxt.pending) begin
                case (w.opcode)
                    fsl_pkg::OP_ON: begin
                        launch      = !nxt.lit;
                        launch_mode = fsl_pkg::MODE_ON;
                    end
                    fsl_pkg::OP_OFF: begin
                        launch      = nxt.lit;
                        launch_mode = fsl_pkg::MODE_OFF;
                    end
                    fsl_pkg::OP_BLINK: begin
                        launch      = 1'b1;
                        launch_mode = fsl_pkg::MODE_BLINK;
                    end
                    default: begin
                        launch      = 1'b1;
                        launch_mode = nxt.lit ? fsl_pkg::MODE_OFF : fsl_pkg::MODE_ON;
                    end
                endcase
            end
        end

        if (launch) begin
            nxt.pending = 1'b1;
            nxt.mode    = launch_mode;
            nxt.level   = (launch_mode == fsl_pkg::MODE_OFF) ? cfg.target
                                                             : fsl_pkg::DUTY_W'(0);
            nxt.idx     = nxt.rev ? fsl_pkg::IDX_W'(lights - 1) : fsl_pkg::IDX_W'(0);
            // blink keeps the old time stamp
            if (launch_mode != fsl_pkg::MODE_BLINK) begin
                nxt.elapsed = '0;
            end
        end
        res.lights_on = nxt.lit;
        res.busy_res  = nxt.pending;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic fsl_pkg::item_t make_word(logic [2:0] op, logic rev,
                                                 logic [fsl_pkg::DUTY_W-1:0] step,
                                                 logic [fsl_pkg::HOLD_W-1:0] hold);
        fsl_pkg::item_t w;
        w.opcode     = op;
        w.go_reverse = rev;
        w.ramp_step  = step;
        w.hold_ticks = hold;
        return w;
    endfunction

    // Queue a word and run it through the planning copy; report whether it
    // did real work (a tick during an animation, or a command that started one).
    function automatic bit queue_word(fsl_pkg::item_t w);
        lamp_state_t      prior;
        fsl_pkg::result_t dropped;
        prior = plan_st;
        fade_step(plan_st, plan_cfg, w, plan_st, dropped);
        cmd_queue = {cmd_queue, w};
        return (w.opcode == fsl_pkg::OP_TICK && prior.pending)
            || (!prior.pending && plan_st.pending);
    endfunction

    // Random fields. Keep the step large enough that a ramp ends in a few
    // dozen ticks, and keep the hold short whenever a blink will use it.
    function automatic fsl_pkg::item_t random_word(logic [2:0] op);
        fsl_pkg::item_t w;
        int             min_step;
        min_step     = int'(plan_cfg.target >> 5) + 1;
        w.opcode     = op;
        w.go_reverse = 1'($urandom_range(1));
        if ($urandom_range(99) < 15) begin
            w.ramp_step = fsl_pkg::DUTY_W'($urandom_range(min_step + 63, min_step));
        end else begin
            w.ramp_step = fsl_pkg::DUTY_W'($urandom_range(4095, min_step));
        end
        if (plan_st.mode == fsl_pkg::MODE_BLINK
            || (op == fsl_pkg::OP_BLINK && !plan_st.pending)) begin
            w.hold_ticks = fsl_pkg::HOLD_W'($urandom_range(24));
        end else begin
            w.hold_ticks = fsl_pkg::HOLD_W'($urandom());
        end
        return w;
    endfunction

    task automatic run_to_rest();
        while (plan_st.pending) begin
            void'(queue_word(make_word(fsl_pkg::OP_TICK, 1'b0, '0, '0)));
        end
    endtask

    // Mostly whole animations: a command, then ticks until it ends, with
    // stray commands and unused opcodes mixed in. Always finish at rest.
    task automatic random_traffic(int quota);
        int         worked;
        logic [2:0] op;
        worked = 0;
        while (worked < quota || plan_st.pending) begin
            if (plan_st.pending) begin
                op = ($urandom_range(99) < 88) ? fsl_pkg::OP_TICK : 3'($urandom_range(7));
            end else if ($urandom_range(99) < 85) begin
                op = 3'($urandom_range(fsl_pkg::OP_TOGGLE, fsl_pkg::OP_ON));
            end else if ($urandom_range(1) == 1) begin
                op = fsl_pkg::OP_TICK;
            end else begin
                op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            end
            if (queue_word(random_word(op))) begin
                worked++;
            end
        end
    endtask

    task automatic write_reg(fsl_pkg::cfg_reg_t which, logic [fsl_pkg::DUTY_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (which == fsl_pkg::CFG_TARGET) begin
            plan_cfg.target = value;
        end else begin
            plan_cfg.count = value[fsl_pkg::COUNT_W-1:0];
        end
        track_cfg = plan_cfg;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every queued word to go in and every result to come out,
    // then let the pipe settle.
    task automatic wait_drained();
        do @(posedge aclk);
        while (cmd_queue.size() != 0 || s_valid || pwm_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Input side: note each word taken and predict its result there.
    always @(posedge aclk) begin : word_monitor
        fsl_pkg::result_t predicted;
        word_taken = aresetn && s_valid && s_ready;
        if (word_taken) begin
            fade_step(track_st, track_cfg, cur_word, track_st, predicted);
            pwm_expect_q = {pwm_expect_q, predicted};
        end
    end

    // Offer the next word on the falling edge; hold the current one until taken.
    always @(negedge aclk) begin : word_driver
        if (aresetn && (!s_valid || word_taken)) begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_word = cmd_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side ready: random stalls plus the long hold-off.
    always @(negedge aclk) begin : result_ready_driver
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hold the result side off long enough for the block to back up.
    initial begin : long_hold
        wait (hold_request);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Compare every result word with the oldest prediction, field by field.
    always @(posedge aclk) begin : result_monitor
        fsl_pkg::result_t got;
        fsl_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_write_valid, m_pwm_channel, m_pwm_duty, m_lights_on, m_busy_res};
            if (pwm_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %h", got));
            end else begin
                want = pwm_expect_q.pop_front();
                if (got.write_valid !== want.write_valid)
                    report_mismatch($sformatf("word %0d write_valid got %b want %b",
                                              results_seen, got.write_valid, want.write_valid));
                if (got.pwm_channel !== want.pwm_channel)
                    report_mismatch($sformatf("word %0d pwm_channel got %0d want %0d",
                                              results_seen, got.pwm_channel, want.pwm_channel));
                if (got.pwm_duty !== want.pwm_duty)
                    report_mismatch($sformatf("word %0d pwm_duty got %0d want %0d",
                                              results_seen, got.pwm_duty, want.pwm_duty));
                if (got.lights_on !== want.lights_on)
                    report_mismatch($sformatf("word %0d lights_on got %b want %b",
                                              results_seen, got.lights_on, want.lights_on));
                if (got.busy_res !== want.busy_res)
                    report_mismatch($sformatf("word %0d busy_res got %b want %b",
                                              results_seen, got.busy_res, want.busy_res));
            end
            results_seen++;
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Two lights keep the hand-written sequence short.
        write_reg(fsl_pkg::CFG_COUNT, 12'd2);

        // Idle ticks and unused opcodes with every field bit set: no effect.
        void'(queue_word(make_word(fsl_pkg::OP_TICK, 1'b0, '0, '0)));
        void'(queue_word(make_word(OP_UNUSED_LO, 1'b1, '1, '1)));
        void'(queue_word(make_word(OP_UNUSED_HI, 1'b1, '1, '1)));
        // off while dark is ignored but still loads its fields
        void'(queue_word(make_word(fsl_pkg::OP_OFF, 1'b1, '1, '1)));
        // full-step fade on, forward, with a repeated on while busy
        void'(queue_word(make_word(fsl_pkg::OP_ON, 1'b0, '1, '1)));
        void'(queue_word(make_word(fsl_pkg::OP_TICK, 1'b0, '0, '0)));
        void'(queue_word(make_word(fsl_pkg::OP_ON, 1'b0, '1, '0)));
        repeat (3) void'(queue_word(make_word(fsl_pkg::OP_TICK, 1'b0, '0, '0)));
        // on while lit is ignored; toggle then fades off in reverse
        void'(queue_word(make_word(fsl_pkg::OP_ON, 1'b1, 12'd800, 20'd5)));
        void'(queue_word(make_word(fsl_pkg::OP_TOGGLE, 1'b1, 12'd2048, '0)));
        repeat (6) void'(queue_word(make_word(fsl_pkg::OP_TICK, 1'b0, '0, '0)));
        // blink holding one tick, then blink in reverse with no hold
        void'(queue_word(make_word(fsl_pkg::OP_BLINK, 1'b0, '1, 20'd1)));
        run_to_rest();
        void'(queue_word(make_word(fsl_pkg::OP_BLINK, 1'b1, '1, '0)));
        run_to_rest();
        wait_drained();

        // A zero step never finishes a ramp: the block stays busy. Release it
        // by dropping the target to zero, then fade off with a zero step too.
        void'(queue_word(make_word(fsl_pkg::OP_ON, 1'b0, '0, '0)));
        repeat (4) void'(queue_word(make_word(fsl_pkg::OP_TICK, 1'b0, '0, '0)));
        wait_drained();
        write_reg(fsl_pkg::CFG_TARGET, 12'd0);
        run_to_rest();
        void'(queue_word(make_word(fsl_pkg::OP_OFF, 1'b0, '0, '0)));
        run_to_rest();
        wait_drained();

        // Full row at full duty, no idling; hold the result side off early on.
        write_reg(fsl_pkg::CFG_TARGET, fsl_pkg::TARGET_RESET);
        write_reg(fsl_pkg::CFG_COUNT, 12'(fsl_pkg::COUNT_MAX));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_traffic(360);
        hold_request = 1'b1;
        wait_drained();

        // Count of zero with junk above the field: clamps to one light.
        write_reg(fsl_pkg::CFG_TARGET, 12'($urandom_range(4095)));
        write_reg(fsl_pkg::CFG_COUNT, 12'hFE0);
        send_idle_pct  = 51;
        recv_stall_pct = 0;
        random_traffic(300);
        wait_drained();

        // Zero target and a count above the maximum.
        write_reg(fsl_pkg::CFG_TARGET, 12'd0);
        write_reg(fsl_pkg::CFG_COUNT, 12'd31);
        send_idle_pct  = 0;
        recv_stall_pct = 51;
        random_traffic(220);
        wait_drained();

        write_reg(fsl_pkg::CFG_TARGET, 12'($urandom_range(4095)));
        write_reg(fsl_pkg::CFG_COUNT, 12'($urandom_range(16, 1)));
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        random_traffic(310);
        wait_drained();

        write_reg(fsl_pkg::CFG_TARGET, 12'($urandom_range(4095, 1)));
        write_reg(fsl_pkg::CFG_COUNT, 12'($urandom_range(16, 1)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_traffic(310);
        wait_drained();

        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (pwm_expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d result words never arrived", pwm_expect_q.size()));
        end
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
